FILE: hw/rtl/jtd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jtd_pkg: shared types and constants of the tank drive mixer
// Field widths, speed constants, register indexes and zone codes.
// ----------------------------------------------------------------------------
package jtd_pkg;

   // field widths
   localparam int DB_W    = 8;    // dead band register
   localparam int POS_W   = 10;   // joystick samples and centre registers
   localparam int CSR_W   = 10;   // widest register
   localparam int SPEED_W = 7;    // wheel speed magnitude 0..100
   localparam int SS_W    = 8;    // signed throttle speed
   localparam int PWM_W   = 8;

   // quotient bits of the divider, one per pipeline stage
   localparam int QUO_W   = 7;
   // numerator: a 10-bit difference times 100 or 90
   localparam int DIFF_W  = 10;
   localparam int NUM_W   = 17;

   // speed constants
   localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;
   localparam logic [SPEED_W-1:0] ROT_SPEED = 7'd50;
   localparam logic [SPEED_W-1:0] TURN_MAX  = 7'd90;

   // speed * 255 / 100 as a multiply by a scaled reciprocal
   localparam int PWM_RECIP_W = 21;
   localparam logic [PWM_RECIP_W-1:0] PWM_RECIP = 21'd1336965;
   localparam int PWM_SHIFT   = 19;

   // register reset values
   localparam logic [DB_W-1:0]  DB_RESET = 8'd30;
   localparam logic [POS_W-1:0] CX_RESET = 10'd591;
   localparam logic [POS_W-1:0] CY_RESET = 10'd580;

   // register indexes
   typedef enum logic [1:0] {
      CSR_DEAD_BAND = 2'd0,
      CSR_CENTRE_X  = 2'd1,
      CSR_CENTRE_Y  = 2'd2
   } csr_index_type;

   // throttle regions of the Y axis
   typedef enum logic [1:0] {
      THR_NEG  = 2'd0,   // below the dead band, divide by the lower span
      THR_ZERO = 2'd1,   // inside the dead band
      THR_POS  = 2'd2,   // above the dead band, divide by the upper span
      THR_FULL = 2'd3    // upper span empty, full speed
   } region_type;

   // steering zones of the X axis
   typedef enum logic [2:0] {
      ZONE_ROT_L    = 3'd0,
      ZONE_TURN_L   = 3'd1,
      ZONE_STRAIGHT = 3'd2,
      ZONE_TURN_R   = 3'd3,
      ZONE_ROT_R    = 3'd4
   } zone_type;

endpackage
`default_nettype wire

FILE: hw/rtl/jtd_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jtd_div: pipelined restoring divider
// One quotient bit per register stage, QUO_W stages, with a side tag that
// travels along. Quotients that do not fit in QUO_W bits raise ovf.
// ----------------------------------------------------------------------------
module jtd_div #(
   parameter int NUM_W = 17,
   parameter int DEN_W = 10,
   parameter int TAG_W = 2
) (
   input  wire logic                        clock,
   input  wire logic [NUM_W-1:0]            num,
   input  wire logic [DEN_W-1:0]            den,
   input  wire logic [TAG_W-1:0]            tag_in,
   output logic      [jtd_pkg::QUO_W-1:0]   quo,
   output logic                             ovf,
   output logic      [TAG_W-1:0]            tag_out
);
   import jtd_pkg::*;

   localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic [NUM_W-1:0] rem_ff [QUO_W];
   logic [NUM_W-1:0] rem_in [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [DEN_W-1:0] den_in [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [QUO_W-1:0] quo_in [QUO_W];
   logic [TAG_W-1:0] tag_ff [QUO_W];
   logic [TAG_W-1:0] tag_in_s [QUO_W];
   logic [QUO_W-1:0] ovf_ff;
   logic [QUO_W-1:0] ovf_in;

   genvar i;
   generate
      for (i = 0; i < QUO_W; i++) begin : g_stage
         logic [NUM_W-1:0] rem_src;
         logic [DEN_W-1:0] den_src;
         logic [QUO_W-1:0] quo_src;
         logic [TAG_W-1:0] tag_src;
         logic             ovf_src;
         logic [CW-1:0]    trial;
         logic             take;

         // first stage also checks that the quotient fits
         if (i == 0) begin : g_first
            assign rem_src = num;
            assign den_src = den;
            assign quo_src = '0;
            assign tag_src = tag_in;
            assign ovf_src = (CW'(den) << QUO_W) <= CW'(num);
         end else begin : g_next
            assign rem_src = rem_ff[i-1];
            assign den_src = den_ff[i-1];
            assign quo_src = quo_ff[i-1];
            assign tag_src = tag_ff[i-1];
            assign ovf_src = ovf_ff[i-1];
         end

         // trial subtract of the shifted divisor
         assign trial = CW'(den_src) << (QUO_W - 1 - i);
         assign take  = CW'(rem_src) >= trial;

         assign rem_in[i]   = take ? rem_src - trial[NUM_W-1:0] : rem_src;
         assign quo_in[i]   = quo_src | (take ? (QUO_W'(1) << (QUO_W - 1 - i)) : '0);
         assign den_in[i]   = den_src;
         assign tag_in_s[i] = tag_src;
         assign ovf_in[i]   = ovf_src;
      end
   endgenerate

   // stage registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      tag_ff <= tag_in_s;
      ovf_ff <= ovf_in;
   end

   assign quo     = quo_ff[QUO_W-1];
   assign ovf     = ovf_ff[QUO_W-1];
   assign tag_out = tag_ff[QUO_W-1];

endmodule
`default_nettype wire

FILE: hw/rtl/joystick_tank_drive_mixer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// joystick_tank_drive_mixer: joystick to differential drive mixer
// Maps one X/Y joystick sample to wheel directions, PWM duties and a signed
// throttle speed, through a ten stage pipeline.
// ----------------------------------------------------------------------------
//
// channel    ports                                   handshake
// ---------  --------------------------------------  ---------------------------
// request    req_joy_x, req_joy_y                    start high while busy low
// response   rsp_dir_*, rsp_pwm_*, rsp_signed_speed  rsp_valid strobe, one cycle
// config     csr_index, csr_wdata                    csr_write_en, no wait
//
// One sample enters per cycle while busy is low; each sample passes through
// input decode, 7 divider stages of one quotient bit each, mix and PWM scale.
// Throughput is set by the divider pipeline: one transaction per clock.
// Synchronous reset clears the valid bits and restores the registers;
// busy is high during reset only. The receiver cannot stall, so nothing is
// ever held back.
//
module joystick_tank_drive_mixer #(
   parameter int ADC_MAX = 1023
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [jtd_pkg::POS_W-1:0]         req_joy_x,
   input  wire logic [jtd_pkg::POS_W-1:0]         req_joy_y,
   input  wire logic                              csr_write_en,
   input  wire logic [1:0]                        csr_index,
   input  wire logic [jtd_pkg::CSR_W-1:0]         csr_wdata,
   output logic                                   rsp_valid,
   output logic                                   rsp_dir_left,
   output logic                                   rsp_dir_right,
   output logic      [jtd_pkg::PWM_W-1:0]         rsp_pwm_left,
   output logic      [jtd_pkg::PWM_W-1:0]         rsp_pwm_right,
   output logic signed [jtd_pkg::SS_W-1:0]        rsp_signed_speed
);
   import jtd_pkg::*;

   localparam int AW    = $clog2(ADC_MAX + 1);
   localparam int DEN_W = (AW > POS_W) ? AW : POS_W;
   localparam int VW    = DEN_W + 2;
   localparam int LAT   = QUO_W + 3;
   localparam logic signed [VW-1:0] AMAX = VW'(ADC_MAX);
   localparam int PROD_W = SPEED_W + PWM_RECIP_W;

   // configuration registers
   logic [DB_W-1:0]  cfg_db_ff;
   logic [POS_W-1:0] cfg_cx_ff;
   logic [POS_W-1:0] cfg_cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_db_ff <= DB_RESET;
         cfg_cx_ff <= CX_RESET;
         cfg_cy_ff <= CY_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DEAD_BAND: cfg_db_ff <= csr_wdata[DB_W-1:0];
            CSR_CENTRE_X:  cfg_cx_ff <= csr_wdata[POS_W-1:0];
            CSR_CENTRE_Y:  cfg_cy_ff <= csr_wdata[POS_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy = reset;

   // ------------------------------------------------------------------
   // stage A: throttle region, steering zone and divider operands
   // ------------------------------------------------------------------
   logic signed [VW-1:0] x_s, y_s, th_s, cx_s, cy_s;
   logic signed [VW-1:0] lo_s, hi_s, cxl_s, cxh_s, xr_s;
   logic signed [VW-1:0] tdiff_s, tden_s, rdiff_s, rden_s;
   region_type           region_in;
   zone_type             zone_in;
   logic [NUM_W-1:0]     tnum_in, rnum_in;

   assign x_s   = signed'(VW'(req_joy_x));
   assign y_s   = signed'(VW'(req_joy_y));
   assign th_s  = signed'(VW'(cfg_db_ff));
   assign cx_s  = signed'(VW'(cfg_cx_ff));
   assign cy_s  = signed'(VW'(cfg_cy_ff));
   assign lo_s  = cy_s - th_s;
   assign hi_s  = cy_s + th_s;
   assign cxl_s = cx_s - th_s;
   assign cxh_s = cx_s + th_s;
   assign xr_s  = AMAX - th_s;

   // throttle region and operands
   always_comb begin
      if (y_s < lo_s) begin
         region_in = THR_NEG;
      end else if (y_s < hi_s) begin
         region_in = THR_ZERO;
      end else if (AMAX <= hi_s) begin
         region_in = THR_FULL;
      end else begin
         region_in = THR_POS;
      end
      if (region_in == THR_NEG) begin
         tdiff_s = lo_s - y_s;
         tden_s  = lo_s;
      end else begin
         tdiff_s = y_s - hi_s;
         tden_s  = AMAX - hi_s;
      end
   end

   assign tnum_in = NUM_W'(tdiff_s[DIFF_W-1:0]) * NUM_W'(SPEED_MAX);

   // steering zone, later zones take precedence
   always_comb begin
      zone_in = ZONE_STRAIGHT;
      if (x_s <= th_s) begin
         zone_in = ZONE_ROT_L;
      end
      if (x_s > th_s && x_s < cxl_s) begin
         zone_in = ZONE_TURN_L;
      end
      if (x_s >= cxl_s && x_s < cxh_s) begin
         zone_in = ZONE_STRAIGHT;
      end
      if (x_s >= cxh_s && x_s < xr_s) begin
         zone_in = ZONE_TURN_R;
      end
      if (x_s >= xr_s) begin
         zone_in = ZONE_ROT_R;
      end
      if (zone_in == ZONE_TURN_R) begin
         rdiff_s = x_s - cxh_s;
         rden_s  = xr_s - cxh_s;
      end else begin
         rdiff_s = cxl_s - x_s;
         rden_s  = cxl_s - th_s;
      end
   end

   assign rnum_in = NUM_W'(rdiff_s[DIFF_W-1:0]) * NUM_W'(TURN_MAX);

   logic [NUM_W-1:0] a_tnum_ff, a_rnum_ff;
   logic [DEN_W-1:0] a_tden_ff, a_rden_ff;
   region_type       a_region_ff;
   zone_type         a_zone_ff;
   logic             a_valid_ff;

   always_ff @(posedge clock) begin
      a_tnum_ff   <= tnum_in;
      a_rnum_ff   <= rnum_in;
      a_tden_ff   <= tden_s[DEN_W-1:0];
      a_rden_ff   <= rden_s[DEN_W-1:0];
      a_region_ff <= region_in;
      a_zone_ff   <= zone_in;
   end

   // ------------------------------------------------------------------
   // divider stages: throttle speed and turn reduction side by side
   // ------------------------------------------------------------------
   logic [QUO_W-1:0] thr_quo, red_quo;
   logic             thr_ovf, red_ovf;
   logic [1:0]       thr_tag;
   logic [2:0]       red_tag;

   jtd_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .TAG_W (2)
   ) u_thr_div (
      .clock   (clock),
      .num     (a_tnum_ff),
      .den     (a_tden_ff),
      .tag_in  (a_region_ff),
      .quo     (thr_quo),
      .ovf     (thr_ovf),
      .tag_out (thr_tag)
   );

   jtd_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .TAG_W (3)
   ) u_red_div (
      .clock   (clock),
      .num     (a_rnum_ff),
      .den     (a_rden_ff),
      .tag_in  (a_zone_ff),
      .quo     (red_quo),
      .ovf     (red_ovf),
      .tag_out (red_tag)
   );

   // valid bits beside the divider stages
   logic [QUO_W-1:0] dv_ff;
   logic [QUO_W-1:0] dv_in;

   assign dv_in = {dv_ff[QUO_W-2:0], a_valid_ff};

   // ------------------------------------------------------------------
   // stage F1: speed, zone mix, inner wheel clamp, direction flip
   // ------------------------------------------------------------------
   region_type       f_region;
   zone_type         f_zone;
   logic [SPEED_W-1:0] mag, red, inner, sl_in, sr_in;
   logic               neg, dl_in, dr_in;
   logic [SS_W-1:0]    sp_in;

   assign f_region = region_type'(thr_tag);
   assign f_zone   = zone_type'(red_tag);
   // an out-of-range reduction only arises outside the turn zones
   assign red      = red_ovf ? TURN_MAX : red_quo;

   always_comb begin
      case (f_region)
         THR_NEG:  mag = thr_quo;
         THR_ZERO: mag = '0;
         THR_POS:  mag = (thr_ovf || thr_quo > SPEED_MAX) ? SPEED_MAX : thr_quo;
         THR_FULL: mag = SPEED_MAX;
         default:  mag = '0;
      endcase
      neg   = (f_region == THR_NEG) && (thr_quo != '0);
      sp_in = neg ? (SS_W'(0) - SS_W'(mag)) : SS_W'(mag);
      inner = (mag > red) ? mag - red : '0;

      case (f_zone)
         ZONE_ROT_L: begin
            dl_in = 1'b1; dr_in = 1'b0; sl_in = ROT_SPEED; sr_in = ROT_SPEED;
         end
         ZONE_TURN_L: begin
            dl_in = 1'b1; dr_in = 1'b1; sl_in = inner; sr_in = mag;
         end
         ZONE_TURN_R: begin
            dl_in = 1'b1; dr_in = 1'b1; sl_in = mag; sr_in = inner;
         end
         ZONE_ROT_R: begin
            dl_in = 1'b0; dr_in = 1'b1; sl_in = ROT_SPEED; sr_in = ROT_SPEED;
         end
         default: begin
            dl_in = 1'b1; dr_in = 1'b1; sl_in = mag; sr_in = mag;
         end
      endcase

      // reverse throttle flips both wheels
      if (neg) begin
         dl_in = ~dl_in;
         dr_in = ~dr_in;
      end
   end

   logic [SPEED_W-1:0] f1_sl_ff, f1_sr_ff;
   logic               f1_dl_ff, f1_dr_ff;
   logic [SS_W-1:0]    f1_sp_ff;
   logic               f1_valid_ff;

   always_ff @(posedge clock) begin
      f1_sl_ff <= sl_in;
      f1_sr_ff <= sr_in;
      f1_dl_ff <= dl_in;
      f1_dr_ff <= dr_in;
      f1_sp_ff <= sp_in;
   end

   // ------------------------------------------------------------------
   // stage F2: speed to PWM duty, speed * 255 / 100 truncated
   // ------------------------------------------------------------------
   logic [PROD_W-1:0] pl_prod, pr_prod;

   assign pl_prod = PROD_W'(f1_sl_ff) * PROD_W'(PWM_RECIP);
   assign pr_prod = PROD_W'(f1_sr_ff) * PROD_W'(PWM_RECIP);

   logic [PWM_W-1:0] out_pl_ff, out_pr_ff;
   logic             out_dl_ff, out_dr_ff;
   logic [SS_W-1:0]  out_sp_ff;
   logic             out_valid_ff;

   always_ff @(posedge clock) begin
      out_pl_ff <= pl_prod[PWM_SHIFT +: PWM_W];
      out_pr_ff <= pr_prod[PWM_SHIFT +: PWM_W];
      out_dl_ff <= f1_dl_ff;
      out_dr_ff <= f1_dr_ff;
      out_sp_ff <= f1_sp_ff;
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         dv_ff        <= '0;
         f1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= start && !busy;
         dv_ff        <= dv_in;
         f1_valid_ff  <= dv_ff[QUO_W-1];
         out_valid_ff <= f1_valid_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_dir_left     = out_dl_ff;
   assign rsp_dir_right    = out_dr_ff;
   assign rsp_pwm_left     = out_pl_ff;
   assign rsp_pwm_right    = out_pr_ff;
   assign rsp_signed_speed = signed'(out_sp_ff);

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------

   // every accepted transaction answers after the pipeline latency
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("response missing after pipeline latency");

   // no response without a transaction accepted one latency earlier
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("response without a matching transaction");

   // opposite directions only when rotating, and then both duties match
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_dir_left != rsp_dir_right)) |->
         (rsp_pwm_left == rsp_pwm_right))
      else $error("rotate response with unequal duties");

   // driving both wheels one way follows the throttle sign
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_dir_left == rsp_dir_right)) |->
         (rsp_dir_left == (rsp_signed_speed >= 0)))
      else $error("wheel direction disagrees with throttle sign");

   // throttle speed stays within full scale
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_signed_speed <= 8'sd100 && rsp_signed_speed >= -8'sd100))
      else $error("throttle speed beyond full scale");

endmodule
`default_nettype wire
